### sv/itaf_pkg.sv
`timescale 1ns / 1ps

package itaf_pkg;

  localparam logic [1:0] OP_DEC  = 2'd0;
  localparam logic [1:0] OP_HEX  = 2'd1;
  localparam logic [1:0] OP_BIN  = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [1:0] TERM_NONE  = 2'd0;
  localparam logic [1:0] TERM_CRLF  = 2'd1;
  localparam logic [1:0] TERM_SPACE = 2'd2;
  localparam logic [1:0] TERM_COMMA = 2'd3;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  mode;
    logic        neg;
    logic [31:0] mag;
    logic [4:0]  top;
    logic [1:0]  term;
  } item_t;

endpackage

### sv/itaf_front.sv
`timescale 1ns / 1ps

module itaf_front (
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  value,
  input  logic [1:0]          opcode,
  input  logic [1:0]          terminator,
  input  logic                full,
  output logic                push,
  output itaf_pkg::item_t     item
);

  logic [31:0] raw;
  logic        small8;
  logic        small16;

  assign raw     = unsigned'(value);
  assign small8  = (raw <= 32'h0000_00FF);
  assign small16 = (raw <= 32'h0000_FFFF);

  assign in_ready = !full;
  // undefined opcode is taken and dropped
  assign push     = in_valid && !full && (opcode != itaf_pkg::OP_NONE);

  always_comb begin
    item.mode = opcode;
    item.term = terminator;
    item.neg  = (opcode == itaf_pkg::OP_DEC) && raw[31];
    item.mag  = item.neg ? (~raw + 32'd1) : raw;
    unique case (opcode)
      itaf_pkg::OP_HEX: item.top = small8 ? 5'd1 : (small16 ? 5'd3 : 5'd7);
      itaf_pkg::OP_BIN: item.top = small8 ? 5'd7 : (small16 ? 5'd15 : 5'd31);
      default:          item.top = 5'd0;
    endcase
  end

endmodule

### sv/itaf_queue.sv
`timescale 1ns / 1ps

module itaf_queue #(
  parameter int DEPTH = itaf_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  itaf_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output itaf_pkg::item_t pop_item,
  output logic            empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  itaf_pkg::item_t mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### sv/itaf_back.sv
`timescale 1ns / 1ps

module itaf_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  input  itaf_pkg::item_t item,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [6:0]      char_byte,
  output logic            last
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_PRE0 = 3'd2;
  localparam logic [2:0] S_PRE1 = 3'd3;
  localparam logic [2:0] S_DIG  = 3'd4;
  localparam logic [2:0] S_T0   = 3'd5;
  localparam logic [2:0] S_T1   = 3'd6;

  localparam logic [6:0] CH_ZERO  = 7'd48;
  localparam logic [6:0] CH_ONE   = 7'd49;
  localparam logic [6:0] CH_ALPHA = 7'd55;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_X     = 7'h78;
  localparam logic [6:0] CH_B     = 7'h62;
  localparam logic [6:0] CH_CR    = 7'h0D;
  localparam logic [6:0] CH_LF    = 7'h0A;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_COMMA = 7'h2C;

  localparam int BITS = 32;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [1:0]       mode;
  logic             neg;
  logic [1:0]       term;
  logic [31:0]      raw;
  logic [9:0][3:0]  bcd;
  logic [9:0][3:0]  bcd_adj;
  logic [39:0]      bcd_next;
  logic [9:0][3:0]  bcd_view;
  logic [3:0]       top_dec;
  logic [4:0]       cnt;
  logic [4:0]       bitcnt;
  logic             conv_done;
  logic             adv;
  logic             emit;
  logic [6:0]       ch;
  logic             lst;
  logic             out_valid_next;
  logic [7:0][3:0]  nibs;
  logic [3:0]       nib;
  logic [6:0]       dig_ch;

  assign adv       = !out_valid || out_ready;
  assign pop       = (state == S_IDLE) && !empty;
  assign conv_done = (bitcnt == 5'(BITS - 1));
  assign nibs      = raw;
  assign nib       = nibs[cnt[2:0]];

  // shift-and-add-3 binary to bcd, one bit per cycle
  always_comb begin
    for (int i = 0; i < 10; i++) begin
      bcd_adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
    bcd_next = {bcd_adj[9][2:0], bcd_adj[8:0], raw[31]};
  end

  always_comb begin
    bcd_view = bcd_next;
    top_dec  = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (bcd_view[i] != 4'd0) begin
        top_dec = 4'(i);
      end
    end
  end

  always_comb begin
    unique case (mode)
      itaf_pkg::OP_DEC: dig_ch = CH_ZERO + {3'd0, bcd[cnt[3:0]]};
      itaf_pkg::OP_HEX: dig_ch = (nib > 4'd9) ? CH_ALPHA + {3'd0, nib} : CH_ZERO + {3'd0, nib};
      itaf_pkg::OP_BIN: dig_ch = raw[cnt] ? CH_ONE : CH_ZERO;
      default:          dig_ch = CH_ZERO;
    endcase
  end

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    ch         = CH_ZERO;
    lst        = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (!empty) begin
          state_next = (item.mode == itaf_pkg::OP_DEC) ? S_CONV : S_PRE0;
        end
      end
      S_CONV: begin
        if (conv_done) begin
          state_next = neg ? S_PRE0 : S_DIG;
        end
      end
      S_PRE0: begin
        emit = 1'b1;
        ch   = (mode == itaf_pkg::OP_DEC) ? CH_MINUS : CH_ZERO;
        if (adv) begin
          state_next = (mode == itaf_pkg::OP_DEC) ? S_DIG : S_PRE1;
        end
      end
      S_PRE1: begin
        emit = 1'b1;
        ch   = (mode == itaf_pkg::OP_HEX) ? CH_X : CH_B;
        if (adv) begin
          state_next = S_DIG;
        end
      end
      S_DIG: begin
        emit = 1'b1;
        ch   = dig_ch;
        lst  = (cnt == 5'd0) && (term == itaf_pkg::TERM_NONE);
        if (adv && (cnt == 5'd0)) begin
          state_next = (term == itaf_pkg::TERM_NONE) ? S_IDLE : S_T0;
        end
      end
      S_T0: begin
        emit = 1'b1;
        lst  = (term != itaf_pkg::TERM_CRLF);
        unique case (term)
          itaf_pkg::TERM_CRLF:  ch = CH_CR;
          itaf_pkg::TERM_SPACE: ch = CH_SPACE;
          itaf_pkg::TERM_COMMA: ch = CH_COMMA;
          default:              ch = CH_SPACE;
        endcase
        if (adv) begin
          state_next = (term == itaf_pkg::TERM_CRLF) ? S_T1 : S_IDLE;
        end
      end
      S_T1: begin
        emit = 1'b1;
        ch   = CH_LF;
        lst  = 1'b1;
        if (adv) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    out_valid_next = adv ? emit : out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mode   <= item.mode;
      neg    <= item.neg;
      term   <= item.term;
      raw    <= item.mag;
      cnt    <= item.top;
      bcd    <= '0;
      bitcnt <= '0;
    end else if (state == S_CONV) begin
      raw    <= raw << 1;
      bcd    <= bcd_next;
      bitcnt <= bitcnt + 5'd1;
      if (conv_done) begin
        cnt <= {1'b0, top_dec};
      end
    end else if ((state == S_DIG) && adv) begin
      cnt <= cnt - 5'd1;
    end
    if (adv && emit) begin
      char_byte <= ch;
      last      <= lst;
    end
  end

  a_dec_digit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIG) && (mode == itaf_pkg::OP_DEC) |-> (cnt <= 5'd9) && (bcd[cnt[3:0]] <= 4'd9))
    else $error("decimal digit out of range");

  a_hex_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIG) && (mode == itaf_pkg::OP_HEX) |-> (cnt < 5'd8))
    else $error("hex digit index out of range");

  a_lf_after_cr: assert property (@(posedge clk) disable iff (rst)
    (state == S_T1) |-> (term == itaf_pkg::TERM_CRLF))
    else $error("line feed without cr lf terminator");

endmodule

### sv/integer_to_ascii_formatter_unit.sv
`timescale 1ns / 1ps

// Formats a 32-bit value as ASCII text (signed decimal, 0x hex or 0b binary, with an
// optional CR LF, space or comma) and sends one 7-bit character per output transfer, with
// last set on the final one; opcode 3 is taken and yields nothing. Inputs go through a
// small queue so a new item can be taken while the previous one is still printing.
// A hex or binary item is loaded and then printed at one character per cycle; a decimal
// item is loaded, run through the bit-serial binary to BCD converter, then printed at one
// character per cycle. Either rate holds only while out_ready lets the output advance.
module integer_to_ascii_formatter_unit #(
  parameter int QUEUE_DEPTH = itaf_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] value,
  input  logic [1:0]         opcode,
  input  logic [1:0]         terminator,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [6:0]         char_byte,
  output logic               last
);

  logic            push;
  logic            full;
  logic            pop;
  logic            empty;
  itaf_pkg::item_t push_item;
  itaf_pkg::item_t pop_item;

  itaf_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .opcode     (opcode),
    .terminator (terminator),
    .full       (full),
    .push       (push),
    .item       (push_item)
  );

  itaf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (empty)
  );

  itaf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .item      (pop_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_byte (char_byte),
    .last      (last)
  );

endmodule
